// File: hw/rtl/ive_pkg.sv
// Shared types and constants of the inertia estimator.
// No dependencies; used by the estimator core and its serial multiplier.
package ive_pkg;

  // Configuration register indexes.
  localparam logic [2:0] REG_HPF_ALPHA = 3'd0;
  localparam logic [2:0] REG_FORGET    = 3'd1;
  localparam logic [2:0] REG_B0_NOM    = 3'd2;
  localparam logic [2:0] REG_KT        = 3'd3;
  localparam logic [2:0] REG_EXC_THR   = 3'd4;

  // Coefficient format and smoothing gains (0.01 and 0.001 in Q0.16).
  localparam int COEF_SHIFT = 16;
  localparam int COEF_FAST  = 655;
  localparam int COEF_SLOW  = 66;

  typedef enum logic [4:0] {
    ST_IDLE,
    ST_HPF,
    ST_HPF_W,
    ST_CC,
    ST_CC_W,
    ST_RZ,
    ST_RZ_W,
    ST_SC,
    ST_SC_W,
    ST_RU,
    ST_RU_W,
    ST_CMP,
    ST_DIVR_W,
    ST_TF,
    ST_TF_W,
    ST_TS,
    ST_TS_W,
    ST_GAIN,
    ST_GAIN_W,
    ST_DONE
  } ive_state_e;

endpackage

// File: hw/rtl/iv_inertia_estimator_core.sv
// Instrumental-variable inertia estimator core.
// Depends on ive_pkg, ive_mul and ive_div.
//
// Usage. One input beat per control period carries ref_cmd, ctrl_out and
// dist_obs. Each sample is high-pass filtered, the two forgetting-factor
// correlations are updated, and when the self-correlation is large enough the
// gain estimate is smoothed. Every input beat yields exactly one output beat
// with the inertia estimate, both smoothed estimates and the excited flag.
// A beat moves on a channel at a clock edge where valid is high and stall low.
// All arithmetic runs through one bit-serial multiplier (one multiplier bit
// per cycle) and one restoring divider (one quotient bit per cycle); an
// excited sample also takes the ratio division and two smoothing products.
// One item is worked on at a time. The finished result sits in an output
// register, so the next input beat is taken while the previous result still
// waits on a stalled receiver; the result of that next item is held back
// until the output register frees. Reset clears all filter, correlation and
// estimate state and loads the register defaults. Configuration is written
// through a plain write port; the user must write it only while the block is
// idle, which the block itself does not enforce. Unknown indexes are ignored.
module iv_inertia_estimator_core #(
  parameter int SAMPLE_WIDTH = 32,
  parameter int FRAC_BITS    = 16
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_we_i,
  input  logic [2:0]                     cfg_idx_i,
  input  logic [31:0]                    cfg_data_i,
  input  logic                           in_valid_i,
  output logic                           in_stall_o,
  input  logic signed [SAMPLE_WIDTH-1:0] ref_cmd_i,
  input  logic signed [SAMPLE_WIDTH-1:0] ctrl_out_i,
  input  logic signed [SAMPLE_WIDTH-1:0] dist_obs_i,
  output logic                           out_valid_o,
  input  logic                           out_stall_i,
  output logic [30:0]                    inertia_est_o,
  output logic signed [SAMPLE_WIDTH-1:0] theta_fast_out_o,
  output logic signed [SAMPLE_WIDTH-1:0] theta_slow_out_o,
  output logic                           excited_o
);

  localparam int SW   = SAMPLE_WIDTH;
  localparam int DIVN = 64 + FRAC_BITS;
  localparam int GW   = ((SW > 32) ? SW : 32) + 1;
  localparam int FLOOR_RAW = ((1 << FRAC_BITS) + 5000) / 10000;
  localparam int FLOOR_B   = (FLOOR_RAW < 1) ? 1 : FLOOR_RAW;
  localparam logic signed [64:0] SMAX_X = (65'sd1 <<< (SW - 1)) - 65'sd1;
  localparam logic signed [64:0] SMIN_X = -SMAX_X - 65'sd1;
  localparam logic [DIVN-1:0]    SMAX_Q = DIVN'((65'd1 << (SW - 1)) - 65'd1);

  // Saturate a wide signed value into the sample range.
  function automatic logic signed [SW-1:0] sat_s(input logic signed [64:0] v);
    logic signed [64:0] r;
    r = (v > SMAX_X) ? SMAX_X : ((v < SMIN_X) ? SMIN_X : v);
    return r[SW-1:0];
  endfunction

  function automatic logic signed [63:0] add_sat(input logic signed [63:0] a,
                                                 input logic signed [63:0] b);
    logic [64:0] s;
    s = {a[63], a} + {b[63], b};
    if (s[64] != s[63]) begin
      return s[64] ? {1'b1, 63'd0} : {1'b0, {63{1'b1}}};
    end
    return s[63:0];
  endfunction

  function automatic logic signed [63:0] sx(input logic signed [SW-1:0] v);
    return {{(64-SW){v[SW-1]}}, v};
  endfunction

  ive_pkg::ive_state_e state_q, state_d;

  // Configuration.
  logic [15:0]        alpha_q, lam_q;
  logic signed [31:0] b0_q;
  logic [30:0]        kt_q, thr_q;

  // Datapath state.
  logic signed [SW-1:0] x_q [3];
  logic signed [SW-1:0] pin_q [3];
  logic signed [SW-1:0] pout_q [3];
  logic signed [SW-1:0] filt_q [3];
  logic [1:0]           ch_q;
  logic signed [63:0]   cross_q, self_q, t1_q;
  logic signed [SW-1:0] tf_q, ts_q, raw_q;
  logic                 exc_q;
  logic [30:0]          inert_q;
  logic [30:0]          oinert_q;
  logic signed [SW-1:0] otf_q, ots_q;
  logic                 oexc_q, ovalid_q;

  // Shared units.
  logic               mul_start, mul_shf, mul_done;
  logic signed [63:0] mul_a, mul_res;
  logic signed [SW:0] mul_b;
  logic               div_start, div_done;
  logic [DIVN-1:0]    div_num, div_quot;
  logic [63:0]        div_den;

  logic [63:0]          self_mag, cross_mag;
  logic                 exc_hit, out_free;
  logic signed [GW-1:0] real_b, gain_b;
  logic signed [SW-1:0] raw_new;
  logic [SW-1:0]        qtrunc;

  assign self_mag  = self_q[63] ? 64'(-self_q) : 64'(self_q);
  assign cross_mag = cross_q[63] ? 64'(-cross_q) : 64'(cross_q);
  assign exc_hit   = self_mag > (64'(thr_q) << FRAC_BITS);
  assign out_free  = !ovalid_q || !out_stall_i;

  // Gain plus nominal, floored before it becomes the divisor.
  assign real_b = {{(GW-SW){ts_q[SW-1]}}, ts_q} + {{(GW-32){b0_q[31]}}, b0_q};
  assign gain_b = (real_b < GW'(FLOOR_B)) ? GW'(FLOOR_B) : real_b;

  // Ratio quotient: saturate when above range, apply the sign otherwise.
  assign qtrunc  = div_quot[SW-1:0];
  assign raw_new = (div_quot > SMAX_Q) ?
                   ((cross_q[63] ^ self_q[63]) ? SMIN_X[SW-1:0] : SMAX_X[SW-1:0]) :
                   ((cross_q[63] ^ self_q[63]) ? -$signed(qtrunc) : $signed(qtrunc));

  ive_mul #(
    .BW      (SW),
    .FracBits(FRAC_BITS)
  ) u_mul (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start_i  (mul_start),
    .a_i      (mul_a),
    .b_i      (mul_b),
    .sh_frac_i(mul_shf),
    .done_o   (mul_done),
    .res_o    (mul_res)
  );

  ive_div #(
    .NW(DIVN)
  ) u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start_i(div_start),
    .num_i  (div_num),
    .den_i  (div_den),
    .done_o (div_done),
    .quot_o (div_quot)
  );

  // Next state.
  always_comb begin
    state_d = state_q;
    case (state_q)
      ive_pkg::ST_IDLE:   if (in_valid_i) state_d = ive_pkg::ST_HPF;
      ive_pkg::ST_HPF:    state_d = ive_pkg::ST_HPF_W;
      ive_pkg::ST_HPF_W: begin
        if (mul_done) state_d = (ch_q == 2'd2) ? ive_pkg::ST_CC : ive_pkg::ST_HPF;
      end
      ive_pkg::ST_CC:     state_d = ive_pkg::ST_CC_W;
      ive_pkg::ST_CC_W:   if (mul_done) state_d = ive_pkg::ST_RZ;
      ive_pkg::ST_RZ:     state_d = ive_pkg::ST_RZ_W;
      ive_pkg::ST_RZ_W:   if (mul_done) state_d = ive_pkg::ST_SC;
      ive_pkg::ST_SC:     state_d = ive_pkg::ST_SC_W;
      ive_pkg::ST_SC_W:   if (mul_done) state_d = ive_pkg::ST_RU;
      ive_pkg::ST_RU:     state_d = ive_pkg::ST_RU_W;
      ive_pkg::ST_RU_W:   if (mul_done) state_d = ive_pkg::ST_CMP;
      ive_pkg::ST_CMP:    state_d = exc_hit ? ive_pkg::ST_DIVR_W : ive_pkg::ST_GAIN;
      ive_pkg::ST_DIVR_W: if (div_done) state_d = ive_pkg::ST_TF;
      ive_pkg::ST_TF:     state_d = ive_pkg::ST_TF_W;
      ive_pkg::ST_TF_W:   if (mul_done) state_d = ive_pkg::ST_TS;
      ive_pkg::ST_TS:     state_d = ive_pkg::ST_TS_W;
      ive_pkg::ST_TS_W:   if (mul_done) state_d = ive_pkg::ST_GAIN;
      ive_pkg::ST_GAIN:   state_d = ive_pkg::ST_GAIN_W;
      ive_pkg::ST_GAIN_W: if (div_done) state_d = ive_pkg::ST_DONE;
      ive_pkg::ST_DONE:   if (out_free) state_d = ive_pkg::ST_IDLE;
      default:            state_d = ive_pkg::ST_IDLE;
    endcase
  end

  // Unit control and operand selection.
  always_comb begin
    mul_start = 1'b0;
    mul_shf   = 1'b0;
    mul_a     = '0;
    mul_b     = '0;
    div_start = 1'b0;
    div_num   = '0;
    div_den   = '0;
    case (state_q)
      ive_pkg::ST_HPF: begin
        mul_start = 1'b1;
        mul_a = sx(pout_q[ch_q]) + sx(x_q[ch_q]) - sx(pin_q[ch_q]);
        mul_b = {{(SW-15){1'b0}}, alpha_q};
      end
      ive_pkg::ST_CC: begin
        mul_start = 1'b1;
        mul_a = cross_q;
        mul_b = {{(SW-15){1'b0}}, lam_q};
      end
      ive_pkg::ST_RZ: begin
        mul_start = 1'b1;
        mul_shf   = 1'b1;
        mul_a = sx(filt_q[0]);
        mul_b = {filt_q[2][SW-1], filt_q[2]};
      end
      ive_pkg::ST_SC: begin
        mul_start = 1'b1;
        mul_a = self_q;
        mul_b = {{(SW-15){1'b0}}, lam_q};
      end
      ive_pkg::ST_RU: begin
        mul_start = 1'b1;
        mul_shf   = 1'b1;
        mul_a = sx(filt_q[0]);
        mul_b = {filt_q[1][SW-1], filt_q[1]};
      end
      ive_pkg::ST_CMP: begin
        div_start = exc_hit;
        div_num   = {cross_mag, FRAC_BITS'(0)};
        div_den   = self_mag;
      end
      ive_pkg::ST_TF: begin
        mul_start = 1'b1;
        mul_a = sx(raw_q) - sx(tf_q);
        mul_b = (SW+1)'(ive_pkg::COEF_FAST);
      end
      ive_pkg::ST_TS: begin
        mul_start = 1'b1;
        mul_a = sx(tf_q) - sx(ts_q);
        mul_b = (SW+1)'(ive_pkg::COEF_SLOW);
      end
      ive_pkg::ST_GAIN: begin
        div_start = 1'b1;
        div_num   = DIVN'({kt_q, FRAC_BITS'(0)});
        div_den   = 64'(gain_b);
      end
      default: begin
      end
    endcase
  end

  assign in_stall_o = (state_q != ive_pkg::ST_IDLE);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= ive_pkg::ST_IDLE;
      alpha_q  <= 16'd65126;
      lam_q    <= 16'd65470;
      b0_q     <= '0;
      kt_q     <= 31'd65536;
      thr_q    <= 31'd650;
      for (int i = 0; i < 3; i++) begin
        pin_q[i]  <= '0;
        pout_q[i] <= '0;
      end
      cross_q  <= '0;
      self_q   <= '0;
      tf_q     <= '0;
      ts_q     <= '0;
      ch_q     <= '0;
      exc_q    <= 1'b0;
      ovalid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (cfg_we_i) begin
        case (cfg_idx_i)
          ive_pkg::REG_HPF_ALPHA: alpha_q <= cfg_data_i[15:0];
          ive_pkg::REG_FORGET:    lam_q   <= cfg_data_i[15:0];
          ive_pkg::REG_B0_NOM:    b0_q    <= cfg_data_i;
          ive_pkg::REG_KT:        kt_q    <= cfg_data_i[30:0];
          ive_pkg::REG_EXC_THR:   thr_q   <= cfg_data_i[30:0];
          default: begin
          end
        endcase
      end
      // A new result may load in the same cycle as the waiting one leaves.
      if (state_q == ive_pkg::ST_DONE && out_free) begin
        ovalid_q <= 1'b1;
      end else if (ovalid_q && !out_stall_i) begin
        ovalid_q <= 1'b0;
      end
      case (state_q)
        ive_pkg::ST_IDLE: begin
          ch_q  <= '0;
          exc_q <= 1'b0;
        end
        ive_pkg::ST_HPF_W: begin
          if (mul_done) begin
            pin_q[ch_q]  <= x_q[ch_q];
            pout_q[ch_q] <= sat_s({mul_res[63], mul_res});
            ch_q         <= ch_q + 2'd1;
          end
        end
        ive_pkg::ST_RZ_W: if (mul_done) cross_q <= add_sat(t1_q, mul_res);
        ive_pkg::ST_RU_W: if (mul_done) self_q <= add_sat(t1_q, mul_res);
        ive_pkg::ST_TF_W: begin
          if (mul_done) tf_q <= sat_s({{(65-SW){tf_q[SW-1]}}, tf_q} + {mul_res[63], mul_res});
        end
        ive_pkg::ST_TS_W: begin
          if (mul_done) begin
            ts_q  <= sat_s({{(65-SW){ts_q[SW-1]}}, ts_q} + {mul_res[63], mul_res});
            exc_q <= 1'b1;
          end
        end
        default: begin
        end
      endcase
    end
  end

  // Payload registers. The inertia is staged so that a result still waiting
  // on the receiver keeps its value until the new one is moved over.
  always_ff @(posedge clk_i) begin
    case (state_q)
      ive_pkg::ST_IDLE: begin
        x_q[0] <= ref_cmd_i;
        x_q[1] <= ctrl_out_i;
        x_q[2] <= dist_obs_i;
      end
      ive_pkg::ST_HPF_W: if (mul_done) filt_q[ch_q] <= sat_s({mul_res[63], mul_res});
      ive_pkg::ST_CC_W:  if (mul_done) t1_q <= mul_res;
      ive_pkg::ST_SC_W:  if (mul_done) t1_q <= mul_res;
      ive_pkg::ST_DIVR_W: if (div_done) raw_q <= raw_new;
      ive_pkg::ST_GAIN_W: begin
        if (div_done) inert_q <= (|div_quot[DIVN-1:31]) ? {31{1'b1}} : div_quot[30:0];
      end
      ive_pkg::ST_DONE: begin
        if (out_free) begin
          oinert_q <= inert_q;
          otf_q    <= tf_q;
          ots_q    <= ts_q;
          oexc_q   <= exc_q;
        end
      end
      default: begin
      end
    endcase
  end

  assign out_valid_o      = ovalid_q;
  assign inertia_est_o    = oinert_q;
  assign theta_fast_out_o = otf_q;
  assign theta_slow_out_o = ots_q;
  assign excited_o        = oexc_q;

endmodule

// File: hw/rtl/ive_mul.sv
// Bit-serial signed multiplier with floor shift and 64-bit saturation.
// Depends on ive_pkg for the coefficient shift.
module ive_mul #(
  parameter int BW       = 32,
  parameter int FracBits = 16
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start_i,
  input  logic signed [63:0] a_i,
  input  logic signed [BW:0] b_i,
  input  logic               sh_frac_i,
  output logic               done_o,
  output logic signed [63:0] res_o
);

  localparam int PW = 64 + BW;
  localparam int CW = $clog2(BW + 1);

  logic [63:0]    amag_q, amag_d;
  logic [BW-1:0]  bsh_q, bsh_d;
  logic [PW-1:0]  acc_q, acc_d;
  logic           neg_q, neg_d, shf_q, shf_d;
  logic [CW-1:0]  cnt_q, cnt_d;
  logic           fin_q, fin_d, done_q, done_d;
  logic signed [63:0] res_q, res_d;
  logic [64:0]    sum;
  logic signed [BW:0] bneg;

  // Floor (or ceiling of magnitude when negative) shift, saturated to 64 bits.
  function automatic logic signed [63:0] post(input logic [PW-1:0] p, input logic neg,
                                              input logic shf);
    logic [PW-1:0] q;
    logic          dropped;
    logic [64:0]   m;
    logic signed [63:0] r;
    q       = shf ? (p >> FracBits) : (p >> ive_pkg::COEF_SHIFT);
    dropped = shf ? (|p[FracBits-1:0]) : (|p[ive_pkg::COEF_SHIFT-1:0]);
    m       = {1'b0, q[63:0]} + {64'd0, dropped};
    if (|q[PW-1:64]) begin
      r = neg ? {1'b1, 63'd0} : {1'b0, {63{1'b1}}};
    end else if (neg) begin
      r = (m >= {2'b01, 63'd0}) ? {1'b1, 63'd0} : -$signed(m[63:0]);
    end else begin
      r = q[63] ? {1'b0, {63{1'b1}}} : $signed(q[63:0]);
    end
    return r;
  endfunction

  assign bneg = -b_i;
  assign sum  = {1'b0, acc_q[PW-1:BW]} + (bsh_q[0] ? {1'b0, amag_q} : 65'd0);

  always_comb begin
    amag_d = amag_q;
    bsh_d  = bsh_q;
    acc_d  = acc_q;
    neg_d  = neg_q;
    shf_d  = shf_q;
    cnt_d  = cnt_q;
    fin_d  = 1'b0;
    done_d = 1'b0;
    res_d  = res_q;
    if (start_i) begin
      amag_d = a_i[63] ? 64'(-a_i) : 64'(a_i);
      bsh_d  = b_i[BW] ? bneg[BW-1:0] : b_i[BW-1:0];
      neg_d  = a_i[63] ^ b_i[BW];
      shf_d  = sh_frac_i;
      acc_d  = '0;
      cnt_d  = CW'(BW);
    end else if (cnt_q != '0) begin
      acc_d = {sum, acc_q[BW-1:1]};
      bsh_d = bsh_q >> 1;
      cnt_d = cnt_q - 1'b1;
      fin_d = (cnt_q == CW'(1));
    end else if (fin_q) begin
      res_d  = post(acc_q, neg_q, shf_q);
      done_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      fin_q  <= 1'b0;
      done_q <= 1'b0;
    end else begin
      cnt_q  <= cnt_d;
      fin_q  <= fin_d;
      done_q <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    amag_q <= amag_d;
    bsh_q  <= bsh_d;
    acc_q  <= acc_d;
    neg_q  <= neg_d;
    shf_q  <= shf_d;
    res_q  <= res_d;
  end

  assign done_o = done_q;
  assign res_o  = res_q;

endmodule

// File: hw/rtl/ive_div.sv
// Restoring unsigned divider, one quotient bit per cycle.
// No package dependencies.
module ive_div #(
  parameter int NW = 80
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          start_i,
  input  logic [NW-1:0] num_i,
  input  logic [63:0]   den_i,
  output logic          done_o,
  output logic [NW-1:0] quot_o
);

  localparam int CW = $clog2(NW + 1);

  logic [NW-1:0] num_q, num_d;
  logic [63:0]   den_q, den_d, rem_q, rem_d;
  logic [CW-1:0] cnt_q, cnt_d;
  logic          done_q, done_d;
  logic [64:0]   r2;
  logic          qbit;

  assign r2   = {rem_q, num_q[NW-1]};
  assign qbit = (r2 >= {1'b0, den_q});

  always_comb begin
    num_d  = num_q;
    den_d  = den_q;
    rem_d  = rem_q;
    cnt_d  = cnt_q;
    done_d = 1'b0;
    if (start_i) begin
      num_d = num_i;
      den_d = den_i;
      rem_d = '0;
      cnt_d = CW'(NW);
    end else if (cnt_q != '0) begin
      rem_d  = qbit ? 64'(r2 - {1'b0, den_q}) : r2[63:0];
      num_d  = {num_q[NW-2:0], qbit};
      cnt_d  = cnt_q - 1'b1;
      done_d = (cnt_q == CW'(1));
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      done_q <= 1'b0;
    end else begin
      cnt_q  <= cnt_d;
      done_q <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    num_q <= num_d;
    den_q <= den_d;
    rem_q <= rem_d;
  end

  assign done_o = done_q;
  assign quot_o = num_q;

endmodule

// File: tb/tb.sv
// Self-checking testbench of the instrumental-variable inertia estimator core.
// Depends on ive_pkg and iv_inertia_estimator_core, which needs ive_mul and ive_div.
`timescale 1ns / 100ps

module tb;

  // Index that no register answers to; a write to it must change nothing.
  localparam logic [2:0] REG_NONE = 3'd7;
  localparam longint SMAX = 64'sd2147483647;
  localparam longint SMIN = -64'sd2147483648;
  localparam longint LMAX = 64'sh7fffffffffffffff;
  localparam longint LMIN = 64'sh8000000000000000;
  // The gain floor 0.0001 in Q16.16 rounds to seven LSBs.
  localparam longint GAIN_FLOOR = 64'sd7;

  typedef struct packed {
    logic [30:0]        inertia;
    logic signed [31:0] th_fast;
    logic signed [31:0] th_slow;
    logic               excited;
  } estimate_t;

  typedef struct packed {
    logic signed [31:0] r_smp;
    logic signed [31:0] u_smp;
    logic signed [31:0] z_smp;
    logic               known;
    estimate_t          est;
  } sample_row_t;

  logic               clk_i;
  logic               rst_ni;
  logic               cfg_we_i;
  logic [2:0]         cfg_idx_i;
  logic [31:0]        cfg_data_i;
  logic               in_valid_i;
  logic               in_stall_o;
  logic signed [31:0] ref_cmd_i;
  logic signed [31:0] ctrl_out_i;
  logic signed [31:0] dist_obs_i;
  logic               out_valid_o;
  logic               out_stall_i;
  logic [30:0]        inertia_est_o;
  logic signed [31:0] theta_fast_out_o;
  logic signed [31:0] theta_slow_out_o;
  logic               excited_o;

  iv_inertia_estimator_core uut (.*);

  // Predictor state: our own copy of the filters, correlations and estimates.
  longint    alpha_q, lambda_q, b0_q, kt_q, thr_q;
  longint    hp_in [3];
  longint    hp_out[3];
  longint    xcorr, acorr, th_f, th_s;
  estimate_t pending_est[$];
  int        errors;
  int        stall_hold;   // receiver hold-off, counted down by the receiver
  bit        no_idle;      // both sides run flat out while set

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // Watchdog: the slowest correct run is well under ten milliseconds.
  initial begin
    #80ms;
    $display("FAIL");
    $finish;
  end

  function automatic longint clamp32(longint v);
    return v > SMAX ? SMAX : (v < SMIN ? SMIN : v);
  endfunction

  function automatic logic [63:0] magn(longint v);
    return v < 0 ? 64'(-v) : 64'(v);
  endfunction

  function automatic longint add_clamp(longint a, longint b);
    logic signed [64:0] s;
    s = 65'(a) + 65'(b);
    if (s > 65'(LMAX)) return LMAX;
    if (s < 65'(LMIN)) return LMIN;
    return longint'(s);
  endfunction

  // floor(a*b / 2^sh), saturated to 64 bits.
  function automatic longint mul_floor(longint a, longint b, int sh);
    logic signed [127:0] pa, pb, p;
    pa = a;
    pb = b;
    p = (pa * pb) >>> sh;
    if (p > 128'(LMAX)) return LMAX;
    if (p < 128'(LMIN)) return LMIN;
    return longint'(p);
  endfunction

  // Ratio in Q16.16, truncated toward zero and saturated to the sample range.
  function automatic longint ratio_q16(longint num, longint den);
    logic [127:0] un, ud, q;
    bit           neg;
    un  = magn(num);
    ud  = magn(den);
    neg = (num < 0) != (den < 0);
    if (un / ud > 128'(SMAX >>> 16)) return neg ? SMIN : SMAX;
    q = (un << 16) / ud;
    return clamp32(neg ? -longint'(q) : longint'(q));
  endfunction

  function automatic longint high_pass(int ch, longint x);
    longint y;
    y = clamp32(mul_floor(alpha_q, hp_out[ch] + x - hp_in[ch], ive_pkg::COEF_SHIFT));
    hp_in[ch]  = x;
    hp_out[ch] = y;
    return y;
  endfunction

  function automatic estimate_t estimate_step(logic signed [31:0] rs, logic signed [31:0] us,
                                              logic signed [31:0] zs);
    longint      r, u, z, raw, gain;
    logic [63:0] quo;
    estimate_t   e;
    r = high_pass(0, longint'(rs));
    u = high_pass(1, longint'(us));
    z = high_pass(2, longint'(zs));
    xcorr = add_clamp(mul_floor(lambda_q, xcorr, ive_pkg::COEF_SHIFT), mul_floor(r, z, 16));
    acorr = add_clamp(mul_floor(lambda_q, acorr, ive_pkg::COEF_SHIFT), mul_floor(r, u, 16));
    e.excited = 1'b0;
    if (magn(acorr) > (64'(thr_q) << 16)) begin
      raw  = ratio_q16(xcorr, acorr);
      th_f = clamp32(th_f + mul_floor(raw - th_f, ive_pkg::COEF_FAST, ive_pkg::COEF_SHIFT));
      th_s = clamp32(th_s + mul_floor(th_f - th_s, ive_pkg::COEF_SLOW, ive_pkg::COEF_SHIFT));
      e.excited = 1'b1;
    end
    gain = th_s + b0_q;
    if (gain < GAIN_FLOOR) gain = GAIN_FLOOR;
    quo = (64'(kt_q) << 16) / 64'(gain);
    e.inertia = quo > 64'h7fffffff ? 31'h7fffffff : quo[30:0];
    e.th_fast = th_f[31:0];
    e.th_slow = th_s[31:0];
    return e;
  endfunction

  // Register write at a clean cycle; the block must be idle by then.
  task automatic write_reg(logic [2:0] idx, logic [31:0] val);
    @(negedge clk_i);
    cfg_we_i   = 1'b1;
    cfg_idx_i  = idx;
    cfg_data_i = val;
    @(negedge clk_i);
    cfg_we_i = 1'b0;
    case (idx)
      ive_pkg::REG_HPF_ALPHA: alpha_q  = longint'(val[15:0]);
      ive_pkg::REG_FORGET:    lambda_q = longint'(val[15:0]);
      ive_pkg::REG_B0_NOM:    b0_q     = longint'($signed(val));
      ive_pkg::REG_KT:        kt_q     = longint'(val[30:0]);
      ive_pkg::REG_EXC_THR:   thr_q    = longint'(val[30:0]);
      default: ;
    endcase
  endtask

  // Waits until every result is back, plus margin for the block to go idle.
  task automatic drain;
    wait (pending_est.size() == 0);
    repeat (50) @(negedge clk_i);
  endtask

  // Offers one sample beat and holds it until the block accepts it. Inputs
  // change at the falling edge only, so the payload is stable across stalls.
  task automatic send_sample(logic signed [31:0] rs, logic signed [31:0] us,
                             logic signed [31:0] zs, bit known, estimate_t typed);
    estimate_t e;
    int        gap;
    @(negedge clk_i);
    if (!no_idle && $urandom_range(99) < 13) begin
      gap = ($urandom_range(9) == 0) ? $urandom_range(700, 1) : $urandom_range(20, 1);
      in_valid_i = 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    in_valid_i = 1'b1;
    ref_cmd_i  = rs;
    ctrl_out_i = us;
    dist_obs_i = zs;
    do @(posedge clk_i); while (in_stall_o);
    // The beat is accepted at this edge; the configuration is stable now.
    e = estimate_step(rs, us, zs);
    pending_est.push_back(known ? typed : e);
    @(negedge clk_i);
    in_valid_i = 1'b0;
  endtask

  // Receiver: checks each result beat against the oldest expectation and
  // stalls at random, or for a long hold-off when one is requested.
  initial begin
    estimate_t want;
    out_stall_i = 1'b0;
    forever begin
      @(posedge clk_i);
      if (rst_ni && out_valid_o && !out_stall_i) begin
        if (pending_est.size() == 0) begin
          $display("%0t: result beat with nothing expected (inertia %0d)", $time,
                   inertia_est_o);
          errors++;
        end else begin
          want = pending_est.pop_front();
          if (inertia_est_o !== want.inertia) begin
            $display("%0t: inertia_est expected %0d got %0d", $time, want.inertia,
                     inertia_est_o);
            errors++;
          end
          if (theta_fast_out_o !== want.th_fast) begin
            $display("%0t: theta_fast expected %0d got %0d", $time, want.th_fast,
                     theta_fast_out_o);
            errors++;
          end
          if (theta_slow_out_o !== want.th_slow) begin
            $display("%0t: theta_slow expected %0d got %0d", $time, want.th_slow,
                     theta_slow_out_o);
            errors++;
          end
          if (excited_o !== want.excited) begin
            $display("%0t: excited expected %0b got %0b", $time, want.excited, excited_o);
            errors++;
          end
        end
      end
      @(negedge clk_i);
      if (stall_hold > 0) begin
        stall_hold--;
        out_stall_i = 1'b1;
      end else begin
        out_stall_i = !no_idle && ($urandom_range(99) < 13);
      end
    end
  end

  // Random sample with the shape of a real loop: ctrl and dist follow the
  // reference with random gains, so the correlations build up and the
  // estimator gets excited. About one in five is plain noise over all bits.
  task automatic send_random;
    longint    amp, rv, uv, zv, ku, kz;
    estimate_t none;
    none = '0;
    if ($urandom_range(99) < 20) begin
      send_sample($urandom, $urandom, $urandom, 1'b0, none);
    end else begin
      amp = ($urandom_range(19) == 0) ? 64'sd2147483647
                                      : longint'($urandom_range(32'h0100_0000, 32'h0001_0000));
      rv = longint'($urandom_range(32'hffff_ffff)) % (amp + 1);
      if ($urandom_range(1)) rv = -rv;
      ku = longint'($urandom_range(64)) - 16;
      kz = longint'($urandom_range(64)) - 32;
      uv = clamp32((rv * ku) / 16 + longint'($urandom_range(4096)) - 2048);
      zv = clamp32((rv * kz) / 16 + longint'($urandom_range(4096)) - 2048);
      send_sample(rv[31:0], uv[31:0], zv[31:0], 1'b0, none);
    end
  endtask

  // Directed samples. Only the first result is typed in: from reset with zero
  // input all state stays zero and the inertia is kt over the gain floor.
  localparam sample_row_t DIRECTED [12] = '{
    '{32'sd0, 32'sd0, 32'sd0, 1'b1, '{31'd613566756, 32'sd0, 32'sd0, 1'b0}},
    '{32'h7fffffff, 32'h7fffffff, 32'h7fffffff, 1'b0, '0},
    '{32'h80000000, 32'h80000000, 32'h80000000, 1'b0, '0},
    '{32'h7fffffff, 32'h80000000, 32'h7fffffff, 1'b0, '0},
    '{32'h80000000, 32'h7fffffff, 32'h80000000, 1'b0, '0},
    '{32'h00010000, 32'h00010000, 32'hffff0000, 1'b0, '0},
    '{32'hffffffff, 32'h00000001, 32'h55555555, 1'b0, '0},
    '{32'haaaaaaaa, 32'h55555555, 32'haaaaaaaa, 1'b0, '0},
    '{32'h00640000, 32'h00c80000, 32'h00320000, 1'b0, '0},
    '{32'hff9c0000, 32'hff380000, 32'hffce0000, 1'b0, '0},
    '{32'h00640000, 32'h00c80000, 32'h00320000, 1'b0, '0},
    '{32'sd0, 32'sd0, 32'sd0, 1'b0, '0}
  };

  initial begin
    int        n_items;
    estimate_t none;
    none        = '0;
    errors      = 0;
    stall_hold  = 0;
    no_idle     = 1'b0;
    rst_ni      = 1'b0;
    cfg_we_i    = 1'b0;
    cfg_idx_i   = ive_pkg::REG_HPF_ALPHA;
    cfg_data_i  = '0;
    in_valid_i  = 1'b0;
    ref_cmd_i   = '0;
    ctrl_out_i  = '0;
    dist_obs_i  = '0;
    // Register defaults and cleared state, as the block comes out of reset.
    alpha_q  = 65126;
    lambda_q = 65470;
    b0_q     = 0;
    kt_q     = 65536;
    thr_q    = 650;
    foreach (hp_in[i]) begin
      hp_in[i]  = 0;
      hp_out[i] = 0;
    end
    xcorr = 0;
    acorr = 0;
    th_f  = 0;
    th_s  = 0;
    repeat (4) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    foreach (DIRECTED[i])
      send_sample(DIRECTED[i].r_smp, DIRECTED[i].u_smp, DIRECTED[i].z_smp,
                  DIRECTED[i].known, DIRECTED[i].est);

    // Random part in phases, each under its own register setting.
    for (int ph = 0; ph < 7; ph++) begin
      drain();
      case (ph)
        0: begin
          // Low threshold so the estimates move early; an unmapped index too.
          write_reg(ive_pkg::REG_EXC_THR, 32'd10);
          write_reg(REG_NONE, 32'hdeadbeef);
        end
        1: begin
          // All registers at their lower extremes.
          write_reg(ive_pkg::REG_HPF_ALPHA, 32'd0);
          write_reg(ive_pkg::REG_FORGET, 32'd0);
          write_reg(ive_pkg::REG_B0_NOM, 32'h80000000);
          write_reg(ive_pkg::REG_KT, 32'd0);
          write_reg(ive_pkg::REG_EXC_THR, 32'd0);
        end
        2: begin
          // All registers at their upper extremes.
          write_reg(ive_pkg::REG_HPF_ALPHA, 32'hffff);
          write_reg(ive_pkg::REG_FORGET, 32'hffff);
          write_reg(ive_pkg::REG_B0_NOM, 32'h7fffffff);
          write_reg(ive_pkg::REG_KT, 32'h7fffffff);
          write_reg(ive_pkg::REG_EXC_THR, 32'h7fffffff);
        end
        3: begin
          // Negative nominal gain drives the divisor onto its floor.
          write_reg(ive_pkg::REG_HPF_ALPHA, 32'hffff);
          write_reg(ive_pkg::REG_FORGET, 32'hffff);
          write_reg(ive_pkg::REG_B0_NOM, 32'hfff00000);
          write_reg(ive_pkg::REG_KT, 32'h7fffffff);
          write_reg(ive_pkg::REG_EXC_THR, 32'd0);
        end
        default: begin
          write_reg(ive_pkg::REG_HPF_ALPHA, $urandom_range(65535, 50000));
          write_reg(ive_pkg::REG_FORGET, $urandom_range(65535, 60000));
          write_reg(ive_pkg::REG_B0_NOM, $urandom_range(32'h0004_0000) - 32'h0002_0000);
          write_reg(ive_pkg::REG_KT, $urandom_range(32'h7fff_ffff));
          write_reg(ive_pkg::REG_EXC_THR, $urandom_range(2000));
        end
      endcase
      // A long receiver hold-off while the sender keeps offering beats.
      if (ph == 2) stall_hold = 3000;
      no_idle = (ph == 4);
      n_items = (ph == 0) ? 190 : 125;
      repeat (n_items) send_random();
    end
    no_idle = 1'b0;

    wait (pending_est.size() == 0);
    repeat (700) @(posedge clk_i);
    if (errors == 0 && pending_est.size() == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
